// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the rational arithmetic RTL.
// Needs nothing else. Macro bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RAR_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RAR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RAR_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define RAR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/rar_pkg.sv =====
// Types, codes and widths for the rational arithmetic block.
// Used by every module of the block; depends on nothing.
package rar_pkg;
   localparam int WORD_BITS  = 32;
   localparam int MAG_BITS   = WORD_BITS;
   localparam int WIDE_BITS  = 2 * WORD_BITS;
   localparam int CNT_BITS   = $clog2(WIDE_BITS + 1);
   localparam int NUM_BITS   = 32;
   localparam int DEN_BITS   = 31;
   localparam int IN_BITS    = 32;
   localparam int FIFO_DEPTH = 2;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_ADD = 2'd0;
   localparam mode_type MODE_SUB = 2'd1;
   localparam mode_type MODE_MUL = 2'd2;
   localparam mode_type MODE_DIV = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ZERO_DEN = 2'd1;
   localparam status_type ST_DIV_ZERO = 2'd2;
   localparam status_type ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } smag_type;

   typedef struct packed {
      mode_type mode;
      logic     zero_den;
      smag_type an;
      smag_type ad;
      smag_type bn;
      smag_type bd;
   } item_type;
endpackage

// ===== rtl/rar_front.sv =====
// Front end: accepts request words and splits operands into sign and magnitude.
// Depends on rar_pkg; feeds rar_queue.
module rar_front (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rar_pkg::mode_type           req_mode,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_left_numerator,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_left_denominator,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_right_numerator,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_right_denominator,
   input  logic                        q_full,
   output logic                        q_push,
   output rar_pkg::item_type           q_item
);
   function automatic rar_pkg::smag_type word_in(input logic [rar_pkg::IN_BITS-1:0] raw);
      logic [rar_pkg::WORD_BITS-1:0] v;
      rar_pkg::smag_type r;
      v     = raw[rar_pkg::WORD_BITS-1:0];
      r.neg = v[rar_pkg::WORD_BITS-1];
      r.mag = r.neg ? (~v + 1'b1) : v;
      return r;
   endfunction

   always_comb begin
      q_item.mode     = req_mode;
      q_item.an       = word_in(req_left_numerator);
      q_item.ad       = word_in(req_left_denominator);
      q_item.bn       = word_in(req_right_numerator);
      q_item.bd       = word_in(req_right_denominator);
      q_item.zero_den = (q_item.ad.mag == '0) || (q_item.bd.mag == '0);
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
endmodule

// ===== rtl/rar_queue.sv =====
// Short queue of classified words between front and back.
// Depends on rar_pkg.
`include "assert_macros.svh"
module rar_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rar_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output rar_pkg::item_type pop_item
);
   rar_pkg::item_type               mem_ff [rar_pkg::FIFO_DEPTH];
   logic [rar_pkg::PTR_BITS-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [rar_pkg::FCNT_BITS-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == rar_pkg::FCNT_BITS'(rar_pkg::FIFO_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_item = mem_ff[rd_ff];

   function automatic logic [rar_pkg::PTR_BITS-1:0] bump(input logic [rar_pkg::PTR_BITS-1:0] p);
      return (p == rar_pkg::PTR_BITS'(rar_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_in  = push ? bump(wr_ff) : wr_ff;
      rd_in  = pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + rar_pkg::FCNT_BITS'(push) - rar_pkg::FCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   `RAR_ASSERT_IMPLY(a_no_push_full, clock, reset, full, !push)
   `RAR_ASSERT_IMPLY(a_no_pop_empty, clock, reset, !valid, !pop)
   `RAR_ASSERT_IMPLY(a_cnt_range, clock, reset, 1'b1,
      cnt_ff <= rar_pkg::FCNT_BITS'(rar_pkg::FIFO_DEPTH))
endmodule

// ===== rtl/rar_back.sv =====
// Back end: sequencer with shared binary GCD, restoring divider and multiplier.
// Depends on rar_pkg; drains rar_queue and holds the result register.
`include "assert_macros.svh"
module rar_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  rar_pkg::item_type              q_item,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [rar_pkg::NUM_BITS-1:0] rsp_result_numerator,
   output logic [rar_pkg::DEN_BITS-1:0]   rsp_result_denominator,
   output rar_pkg::status_type            rsp_status
);
   localparam int W  = rar_pkg::WORD_BITS;
   localparam int WB = rar_pkg::WIDE_BITS;
   localparam int CB = rar_pkg::CNT_BITS;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RED   = 8'b0000_0010,
      S_GCD   = 8'b0000_0100,
      S_DIVN  = 8'b0000_1000,
      S_DIVD  = 8'b0001_0000,
      S_STORE = 8'b0010_0000,
      S_MUL   = 8'b0100_0000,
      S_ADD   = 8'b1000_0000
   } state_type;

   localparam logic [1:0] PH_LEFT = 2'd0, PH_RIGHT = 2'd1, PH_RES = 2'd2;

   state_type            state_ff, state_in;
   logic                 out_ff, out_in;
   logic [1:0]           phase_ff, phase_in, mstep_ff, mstep_in;
   rar_pkg::mode_type    mode_ff, mode_in;
   rar_pkg::status_type  status_ff, status_in;
   rar_pkg::smag_type    an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [WB-1:0]        n_mag_ff, n_mag_in, d_mag_ff, d_mag_in;
   logic                 n_neg_ff, n_neg_in, d_neg_ff, d_neg_in;
   logic [WB-1:0]        x_mag_ff, x_mag_in, y_mag_ff, y_mag_in;
   logic                 x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic [WB-1:0]        ga_ff, ga_in, gb_ff, gb_in, g_ff, g_in;
   logic [CB-1:0]        gk_ff, gk_in, cnt_ff, cnt_in;
   logic [WB-1:0]        rem_ff, rem_in, quo_ff, quo_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [rar_pkg::NUM_BITS-1:0] rsp_num_ff, rsp_num_in;
   logic [rar_pkg::DEN_BITS-1:0]        rsp_den_ff, rsp_den_in;
   rar_pkg::status_type  rsp_st_ff, rsp_st_in;

   logic [W-1:0]   mul_a, mul_b;
   logic [WB-1:0]  prod;
   logic [WB:0]    div_t;
   logic           div_bit;
   logic [WB-1:0]  div_rem, div_quo;
   logic [WB-1:0]  half;
   logic           ovf;
   logic signed [W-1:0] num_w;

   always_comb begin
      unique case (mstep_ff)
         2'd0: begin
            mul_a = an_ff.mag;
            mul_b = (mode_ff == rar_pkg::MODE_MUL) ? bn_ff.mag : bd_ff.mag;
         end
         2'd1: begin
            mul_a = ad_ff.mag;
            mul_b = bn_ff.mag;
         end
         default: begin
            mul_a = ad_ff.mag;
            mul_b = (mode_ff == rar_pkg::MODE_DIV) ? bn_ff.mag : bd_ff.mag;
         end
      endcase
      prod    = WB'(mul_a) * WB'(mul_b);
      div_t   = {rem_ff, quo_ff[WB-1]};
      div_bit = (div_t >= {1'b0, g_ff});
      div_rem = div_bit ? WB'(div_t - {1'b0, g_ff}) : div_t[WB-1:0];
      div_quo = {quo_ff[WB-2:0], div_bit};
      half    = WB'(1) << (W - 1);
      ovf     = (d_mag_ff > half - 1'b1) ||
                (n_neg_ff ? (n_mag_ff > half) : (n_mag_ff > half - 1'b1));
      num_w   = n_neg_ff ? (~n_mag_ff[W-1:0] + 1'b1) : n_mag_ff[W-1:0];
   end

   always_comb begin
      state_in = state_ff;   out_in = out_ff;       phase_in = phase_ff;
      mstep_in = mstep_ff;   mode_in = mode_ff;     status_in = status_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      n_mag_in = n_mag_ff; d_mag_in = d_mag_ff; n_neg_in = n_neg_ff; d_neg_in = d_neg_ff;
      x_mag_in = x_mag_ff; y_mag_in = y_mag_ff; x_neg_in = x_neg_ff; y_neg_in = y_neg_ff;
      ga_in = ga_ff; gb_in = gb_ff; g_in = g_ff; gk_in = gk_ff; cnt_in = cnt_ff;
      rem_in = rem_ff; quo_in = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in = rsp_num_ff; rsp_den_in = rsp_den_ff; rsp_st_in = rsp_st_ff;
      q_pop = 1'b0;

      if (out_ff) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            rsp_st_in    = status_ff;
            if (status_ff == rar_pkg::ST_OK) begin
               rsp_num_in = rar_pkg::NUM_BITS'(num_w);
               rsp_den_in = rar_pkg::DEN_BITS'(d_mag_ff[W-2:0]);
            end else begin
               rsp_num_in = '0;
               rsp_den_in = rar_pkg::DEN_BITS'(1);
            end
            out_in = 1'b0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  q_pop    = 1'b1;
                  mode_in  = q_item.mode;
                  bn_in    = q_item.bn;
                  bd_in    = q_item.bd;
                  n_mag_in = WB'(q_item.an.mag);
                  n_neg_in = q_item.an.neg;
                  d_mag_in = WB'(q_item.ad.mag);
                  d_neg_in = q_item.ad.neg;
                  phase_in = PH_LEFT;
                  if (q_item.zero_den) begin
                     status_in = rar_pkg::ST_ZERO_DEN;
                     out_in    = 1'b1;
                  end else begin
                     status_in = rar_pkg::ST_OK;
                     state_in  = S_RED;
                  end
               end
            end
            S_RED: begin
               if (n_mag_ff == '0) begin
                  n_neg_in = 1'b0;
                  d_neg_in = 1'b0;
                  d_mag_in = WB'(1);
                  state_in = S_STORE;
               end else begin
                  ga_in    = n_mag_ff;
                  gb_in    = d_mag_ff;
                  gk_in    = '0;
                  state_in = S_GCD;
               end
            end
            S_GCD: begin
               priority if (ga_ff == '0 || gb_ff == '0) begin
                  g_in     = (ga_ff | gb_ff) << gk_ff;
                  quo_in   = n_mag_ff;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIVN;
               end else if (!ga_ff[0] && !gb_ff[0]) begin
                  ga_in = ga_ff >> 1;
                  gb_in = gb_ff >> 1;
                  gk_in = gk_ff + 1'b1;
               end else if (!ga_ff[0]) begin
                  ga_in = ga_ff >> 1;
               end else if (!gb_ff[0]) begin
                  gb_in = gb_ff >> 1;
               end else if (ga_ff >= gb_ff) begin
                  ga_in = ga_ff - gb_ff;
               end else begin
                  gb_in = gb_ff - ga_ff;
               end
            end
            S_DIVN: begin
               rem_in = div_rem;
               quo_in = div_quo;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CB'(WB - 1)) begin
                  n_mag_in = div_quo;
                  quo_in   = d_mag_ff;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_DIVD;
               end
            end
            S_DIVD: begin
               rem_in = div_rem;
               quo_in = div_quo;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CB'(WB - 1)) begin
                  d_mag_in = div_quo;
                  n_neg_in = n_neg_ff ^ d_neg_ff;
                  d_neg_in = 1'b0;
                  state_in = S_STORE;
               end
            end
            S_STORE: begin
               unique case (phase_ff)
                  PH_LEFT: begin
                     an_in    = '{neg: n_neg_ff, mag: n_mag_ff[W-1:0]};
                     ad_in    = '{neg: 1'b0, mag: d_mag_ff[W-1:0]};
                     n_mag_in = WB'(bn_ff.mag);
                     n_neg_in = bn_ff.neg;
                     d_mag_in = WB'(bd_ff.mag);
                     d_neg_in = bd_ff.neg;
                     phase_in = PH_RIGHT;
                     state_in = S_RED;
                  end
                  PH_RIGHT: begin
                     bn_in = '{neg: n_neg_ff, mag: n_mag_ff[W-1:0]};
                     bd_in = '{neg: 1'b0, mag: d_mag_ff[W-1:0]};
                     if (mode_ff == rar_pkg::MODE_DIV && n_mag_ff == '0) begin
                        status_in = rar_pkg::ST_DIV_ZERO;
                        out_in    = 1'b1;
                        state_in  = S_IDLE;
                     end else begin
                        mstep_in = 2'd0;
                        state_in = S_MUL;
                     end
                  end
                  default: begin
                     if (ovf) begin
                        status_in = rar_pkg::ST_OVERFLOW;
                     end
                     out_in   = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end
            S_MUL: begin
               mstep_in = mstep_ff + 1'b1;
               unique case (mstep_ff)
                  2'd0: begin
                     x_mag_in = prod;
                     x_neg_in = an_ff.neg ^ ((mode_ff == rar_pkg::MODE_MUL) && bn_ff.neg);
                  end
                  2'd1: begin
                     y_mag_in = prod;
                     y_neg_in = bn_ff.neg ^ (mode_ff == rar_pkg::MODE_SUB);
                  end
                  default: begin
                     d_mag_in = prod;
                     d_neg_in = (mode_ff == rar_pkg::MODE_DIV) && bn_ff.neg;
                     state_in = S_ADD;
                  end
               endcase
            end
            default: begin
               if (mode_ff == rar_pkg::MODE_ADD || mode_ff == rar_pkg::MODE_SUB) begin
                  priority if (x_neg_ff == y_neg_ff) begin
                     n_mag_in = x_mag_ff + y_mag_ff;
                     n_neg_in = x_neg_ff;
                  end else if (x_mag_ff >= y_mag_ff) begin
                     n_mag_in = x_mag_ff - y_mag_ff;
                     n_neg_in = x_neg_ff;
                  end else begin
                     n_mag_in = y_mag_ff - x_mag_ff;
                     n_neg_in = y_neg_ff;
                  end
               end else begin
                  n_mag_in = x_mag_ff;
                  n_neg_in = x_neg_ff;
               end
               if (n_mag_in == '0) begin
                  n_neg_in = 1'b0;
               end
               phase_in = PH_RES;
               state_in = S_RED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_LEFT;
         mstep_ff     <= 2'd0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_ff       <= out_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         mstep_ff     <= mstep_in;
         cnt_ff       <= cnt_in;
      end
      mode_ff <= mode_in;   status_ff <= status_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      n_mag_ff <= n_mag_in; d_mag_ff <= d_mag_in; n_neg_ff <= n_neg_in; d_neg_ff <= d_neg_in;
      x_mag_ff <= x_mag_in; y_mag_ff <= y_mag_in; x_neg_ff <= x_neg_in; y_neg_ff <= y_neg_in;
      ga_ff <= ga_in; gb_ff <= gb_in; g_ff <= g_in; gk_ff <= gk_in;
      rem_ff <= rem_in; quo_ff <= quo_in;
      rsp_num_ff <= rsp_num_in; rsp_den_ff <= rsp_den_in; rsp_st_ff <= rsp_st_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_numerator   = rsp_num_ff;
   assign rsp_result_denominator = rsp_den_ff;
   assign rsp_status             = rsp_st_ff;

   `RAR_ASSERT_IMPLY(a_err_payload, clock, reset,
      rsp_valid_ff && rsp_st_ff != rar_pkg::ST_OK,
      rsp_num_ff == '0 && rsp_den_ff == rar_pkg::DEN_BITS'(1))
   `RAR_ASSERT_IMPLY(a_div_nonzero, clock, reset,
      !out_ff && (state_ff == S_DIVN || state_ff == S_DIVD), g_ff != '0)
   `RAR_ASSERT_IMPLY(a_gcd_live, clock, reset,
      !out_ff && state_ff == S_GCD, ga_ff != '0 || gb_ff != '0)
   `RAR_ASSERT_NEXT(a_pop_idle, clock, reset, q_pop, state_ff == S_RED || out_ff)
endmodule

// ===== rtl/rational_arith_reduce_top.sv =====
// A zero-denominator word (status 1) answers without any reduction. A full
// operation runs three reductions, each a shared binary GCD and two restoring
// divisions, plus the cross products and their sum.
// Throughput: one word at a time in the back end; a 2-word queue and the
// result register let requests and responses stall independently.
// Reset: synchronous, active high, empties the queue and the sequencer.
module rational_arith_reduce_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rar_pkg::mode_type           req_mode,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_left_numerator,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_left_denominator,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_right_numerator,
   input  logic signed [rar_pkg::IN_BITS-1:0] req_right_denominator,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [rar_pkg::NUM_BITS-1:0] rsp_result_numerator,
   output logic [rar_pkg::DEN_BITS-1:0] rsp_result_denominator,
   output rar_pkg::status_type         rsp_status
);
   logic              q_full, q_push, q_pop, q_valid;
   rar_pkg::item_type push_item, pop_item;

   rar_front u_front (
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_left_numerator    (req_left_numerator),
      .req_left_denominator  (req_left_denominator),
      .req_right_numerator   (req_right_numerator),
      .req_right_denominator (req_right_denominator),
      .q_full                (q_full),
      .q_push                (q_push),
      .q_item                (push_item)
   );

   rar_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   rar_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_item                 (pop_item),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_result_numerator   (rsp_result_numerator),
      .rsp_result_denominator (rsp_result_denominator),
      .rsp_status             (rsp_status)
   );
endmodule

// ===== test/tb_rational_arith_reduce_top.sv =====
// Testbench for rational_arith_reduce_top: directed table then random words,
// each response checked against a typed answer or a behavioral fraction calculator.
// Depends on rar_pkg and the RTL top level only.
module tb_rational_arith_reduce_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      rar_pkg::mode_type  mode;
      logic signed [31:0] ln;
      logic signed [31:0] ld;
      logic signed [31:0] rn;
      logic signed [31:0] rd;
   } frac_req_type;

   typedef struct {
      logic signed [31:0]  num;
      logic [30:0]         den;
      rar_pkg::status_type status;
   } frac_rsp_type;

   typedef struct {
      frac_req_type req;
      logic         typed;
      frac_rsp_type rsp;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rar_pkg::mode_type req_mode = rar_pkg::MODE_ADD;
   logic signed [31:0] req_left_numerator = '0;
   logic signed [31:0] req_left_denominator = 32'sd1;
   logic signed [31:0] req_right_numerator = '0;
   logic signed [31:0] req_right_denominator = 32'sd1;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_numerator;
   logic [30:0] rsp_result_denominator;
   rar_pkg::status_type rsp_status;

   frac_rsp_type answers[$];
   int errors = 0;
   bit stim_done = 0;

   always #5 clock = ~clock;

   rational_arith_reduce_top i_dut (.*);

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      while (a != 0 && b != 0) begin
         if (a > b) a = a % b;
         else b = b % a;
      end
      return a + b;
   endfunction

   // signed arithmetic in 130 bits holds every exact cross product
   function automatic frac_rsp_type calc_fraction(frac_req_type q);
      frac_rsp_type r;
      logic signed [129:0] an, ad, bn, bd, n, d, g;
      logic [129:0] mn, md;
      r.num = '0;
      r.den = 31'd1;
      r.status = rar_pkg::ST_OK;
      if (q.ld == 0 || q.rd == 0) begin
         r.status = rar_pkg::ST_ZERO_DEN;
         return r;
      end
      an = q.ln; ad = q.ld; bn = q.rn; bd = q.rd;
      if (q.mode == rar_pkg::MODE_DIV && bn == 0) begin
         r.status = rar_pkg::ST_DIV_ZERO;
         return r;
      end
      case (q.mode)
         rar_pkg::MODE_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
         rar_pkg::MODE_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
         rar_pkg::MODE_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      if (d < 0) begin n = -n; d = -d; end
      if (n == 0) begin
         d = 1;
      end else begin
         mn = (n < 0) ? -n : n;
         md = d;
         g = gcd64(mn[63:0], md[63:0]);
         n = n / g;
         d = d / g;
      end
      if (d > 130'sd2147483647 || n > 130'sd2147483647 || n < -130'sd2147483648) begin
         r.status = rar_pkg::ST_OVERFLOW;
         return r;
      end
      r.num = n[31:0];
      r.den = d[30:0];
      return r;
   endfunction

   function automatic frac_rsp_type typed_rsp(logic signed [31:0] n, logic [30:0] d,
                                              rar_pkg::status_type s);
      frac_rsp_type r;
      r.num = n; r.den = d; r.status = s;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $signed($urandom());
         1: return $signed(32'h8000_0000 + $urandom_range(0, 2));
         2: return $signed(32'h7fff_ffff - $urandom_range(0, 2));
         3: return $signed($urandom_range(0, 40)) - 20;
         default: return $signed($urandom_range(0, 60000)) - 30000;
      endcase
   endfunction

   task automatic send_word(frac_req_type q, logic typed, frac_rsp_type t);
      req_valid <= 1'b1;
      req_mode <= q.mode;
      req_left_numerator <= q.ln;
      req_left_denominator <= q.ld;
      req_right_numerator <= q.rn;
      req_right_denominator <= q.rd;
      answers.push_back(typed ? t : calc_fraction(q));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(0, 3) != 0) || (($urandom() & 32'h300) == 0);
      end
   end

   always @(posedge clock) begin
      frac_rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            exp_rsp = answers.pop_front();
            if (rsp_result_numerator !== exp_rsp.num) begin
               $error("result_numerator exp %0d got %0d", exp_rsp.num, rsp_result_numerator);
               errors++;
            end
            if (rsp_result_denominator !== exp_rsp.den) begin
               $error("result_denominator exp %0d got %0d", exp_rsp.den,
                      rsp_result_denominator);
               errors++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $error("status exp %0d got %0d", exp_rsp.status, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      table_row_type rows[$];
      frac_req_type q;
      frac_rsp_type none;
      int burst;
      none = typed_rsp(0, 1, rar_pkg::ST_OK);
      rows.push_back('{'{rar_pkg::MODE_ADD, 1, 0, 1, 1}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_ZERO_DEN)});
      rows.push_back('{'{rar_pkg::MODE_DIV, 1, 1, 1, 0}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_ZERO_DEN)});
      rows.push_back('{'{rar_pkg::MODE_DIV, 0, 0, 0, 1}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_ZERO_DEN)});
      rows.push_back('{'{rar_pkg::MODE_DIV, 3, 4, 0, 7}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_DIV_ZERO)});
      rows.push_back('{'{rar_pkg::MODE_DIV, 0, 4, 0, -7}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_DIV_ZERO)});
      rows.push_back('{'{rar_pkg::MODE_ADD, 0, 5, 0, -3}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_OK)});
      rows.push_back('{'{rar_pkg::MODE_ADD, 1, 2, 1, 3}, 1,
                       typed_rsp(5, 6, rar_pkg::ST_OK)});
      rows.push_back('{'{rar_pkg::MODE_SUB, 1, 2, 1, 2}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_OK)});
      rows.push_back('{'{rar_pkg::MODE_MUL, 2, -4, 3, 9}, 1,
                       typed_rsp(-1, 6, rar_pkg::ST_OK)});
      rows.push_back('{'{rar_pkg::MODE_DIV, 1, 2, -1, 4}, 1,
                       typed_rsp(-2, 1, rar_pkg::ST_OK)});
      rows.push_back('{'{rar_pkg::MODE_MUL, 1, 32'sh8000_0000, 1, 1}, 0, none});
      rows.push_back('{'{rar_pkg::MODE_MUL, 1, 32'sh8000_0000, -1, 1}, 0, none});
      rows.push_back('{'{rar_pkg::MODE_MUL, 32'sh8000_0000, 1, -1, 1}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_OVERFLOW)});
      rows.push_back('{'{rar_pkg::MODE_ADD, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1}, 1,
                       typed_rsp(0, 1, rar_pkg::ST_OVERFLOW)});
      rows.push_back('{'{rar_pkg::MODE_SUB, 32'sh8000_0000, 1, 32'sh7fff_ffff, 1}, 0,
                       none});
      rows.push_back('{'{rar_pkg::MODE_DIV, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh7fff_ffff, 32'sh8000_0000}, 0, none});
      rows.push_back('{'{rar_pkg::MODE_MUL, 32'sh7fff_ffff, 32'sh7fff_fffe,
                         32'sh7fff_fffd, 32'sh7fff_ffff}, 0, none});
      rows.push_back('{'{rar_pkg::MODE_ADD, 1, 32'sh7fff_ffff, 1, 32'sh7fff_fffe}, 0,
                       none});
      rows.push_back('{'{rar_pkg::MODE_DIV, -1, -1, -1, -1}, 0, none});
      rows.push_back('{'{rar_pkg::MODE_SUB, 32'shffff_ffff, 32'shffff_ffff, 0,
                         32'sh8000_0000}, 0, none});
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         send_word(rows[i].req, rows[i].typed, rows[i].rsp);
         if ($urandom_range(0, 2) == 0) idle_gap();
      end
      req_valid <= 1'b0;
      while (answers.size() != 0) @(posedge clock);
      for (int n = 0; n < 1350; ) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && n < 1350; k++, n++) begin
            q.mode = rar_pkg::mode_type'($urandom_range(0, 3));
            q.ln = rand_word();
            q.ld = rand_word();
            q.rn = rand_word();
            q.rd = rand_word();
            if (q.ld == 0 && $urandom_range(0, 3) != 0) q.ld = 1;
            if (q.rd == 0 && $urandom_range(0, 3) != 0) q.rd = -1;
            send_word(q, 1'b0, none);
         end
         if (n == 700) begin
            req_valid <= 1'b0;
            while (answers.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 3) != 0) idle_gap();
      end
      req_valid <= 1'b0;
      while (answers.size() != 0) @(posedge clock);
      repeat (900) @(posedge clock);
      if (errors == 0 && answers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
